### sv/pfe_pkg.sv
// shared types and constants of the palette fade engine
package pfe_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned COLOR_W  = 12;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_UPLOAD = 3'd1,
    FN_WR_CUR = 3'd2,
    FN_WR_TGT = 3'd3,
    FN_START  = 3'd4,
    FN_RD_CUR = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_LAST = 2'd2
  } fade_mode_e;

  localparam logic [STATUS_W-1:0] STS_IDLE   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FADING = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DONE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RDWAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic rd_issue;
    logic rd_capture;
    logic sweep_start;
    logic sweep_rd;
    logic pass_end;
  } pfe_cmd_t;

  typedef struct packed {
    func_e func;
    logic  tick_pass;
    logic  sweep_last;
  } pfe_sts_t;

endpackage

### sv/pfe_dp.sv
// datapath: request registers, palette memories, fade state and step logic
module pfe_dp #(
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pfe_pkg::pfe_cmd_t                 cmd_i,
  output pfe_pkg::pfe_sts_t                 sts_o,
  input  logic [pfe_pkg::FUNC_W-1:0]        func_i,
  input  logic [pfe_pkg::IDX_W-1:0]         index_i,
  input  logic [pfe_pkg::COLOR_W-1:0]       color_i,
  input  logic [pfe_pkg::SPEED_W-1:0]       speed_i,
  output logic [pfe_pkg::STATUS_W-1:0]      status_o,
  output logic [pfe_pkg::COLOR_W-1:0]       read_color_o,
  output logic                              upload_o
);
  import pfe_pkg::*;

  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [COLOR_W-1:0] COMP_MASK [3] = '{12'h00E, 12'h0E0, 12'hE00};
  localparam logic [COLOR_W-1:0] COMP_UNIT [3] = '{12'h002, 12'h020, 12'h200};

  // one unit toward the target per component, top bit flags a change
  function automatic logic [COLOR_W:0] step_color(input logic [COLOR_W-1:0] cur,
                                                  input logic [COLOR_W-1:0] tgt);
    logic [COLOR_W-1:0] res;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] t;
    logic               chg;
    res = cur;
    chg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      c = cur & COMP_MASK[k];
      t = tgt & COMP_MASK[k];
      if (c < t) begin
        res = res + COMP_UNIT[k];
        chg = 1'b1;
      end else if (c > t) begin
        res = res - COMP_UNIT[k];
        chg = 1'b1;
      end
    end
    return {chg, res};
  endfunction

  // request registers
  logic [FUNC_W-1:0]  func_q;
  logic [IDX_W-1:0]   idx_q;
  logic [COLOR_W-1:0] color_q;
  logic [SPEED_W-1:0] speed_q;

  // fade state
  fade_mode_e         mode_q, mode_d;
  logic [7:0]         frame_q, frame_d;
  logic [7:0]         div_q, div_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic               changed_q, changed_d;

  // result registers
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COLOR_W-1:0]  rdc_q, rdc_d;
  logic                up_q, up_d;

  // palette memories with per-entry valid bits
  logic [COLOR_W-1:0]         cur_mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0]         tgt_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] cur_vld_q;
  logic [PALETTE_ENTRIES-1:0] tgt_vld_q;
  logic [COLOR_W-1:0]         cur_rd_q, tgt_rd_q;
  logic                       cur_rdv_q, tgt_rdv_q;

  // write-back stage of the sweep
  logic          wb_v_q;
  logic [AW-1:0] wb_addr_q;

  logic [IDX_W+AW-1:0] idx_ext;
  logic [AW-1:0]       idx_addr;
  logic                idx_ok;
  logic [AW-1:0]       rd_addr;
  logic [COLOR_W-1:0]  cur_eff, tgt_eff;
  logic [COLOR_W:0]    step_res;
  logic                cur_we, tgt_we;
  logic [AW-1:0]       cur_waddr;
  logic [COLOR_W-1:0]  cur_wdata;
  logic [8:0]          frame_next, limit;
  logic                tick_hit;
  func_e               func;

  assign func       = func_e'(func_q);
  assign idx_ext    = (IDX_W + AW)'(idx_q);
  assign idx_addr   = idx_ext[AW-1:0];
  assign idx_ok     = (32'(idx_q) < PALETTE_ENTRIES);
  assign rd_addr    = cmd_i.rd_issue ? idx_addr : sweep_q;
  assign cur_eff    = cur_rdv_q ? cur_rd_q : '0;
  assign tgt_eff    = tgt_rdv_q ? tgt_rd_q : '0;
  assign step_res   = step_color(cur_eff, tgt_eff);

  assign frame_next = {1'b0, frame_q} + 9'd1;
  assign limit      = (div_q == 8'd0) ? 9'd1 : {1'b0, div_q};
  assign tick_hit   = (frame_next >= limit);

  assign cur_we    = wb_v_q || (cmd_i.exec && (func == FN_WR_CUR) && idx_ok);
  assign cur_waddr = wb_v_q ? wb_addr_q : idx_addr;
  assign cur_wdata = wb_v_q ? step_res[COLOR_W-1:0] : color_q;
  assign tgt_we    = cmd_i.exec && (func == FN_WR_TGT) && idx_ok;

  assign sts_o.func       = func;
  assign sts_o.tick_pass  = (func == FN_TICK) && (mode_q == MODE_RUN) && tick_hit;
  assign sts_o.sweep_last = (sweep_q == AW'(PALETTE_ENTRIES - 1));

  assign status_o     = status_q;
  assign read_color_o = rdc_q;
  assign upload_o     = up_q;

  always_comb begin
    mode_d    = mode_q;
    frame_d   = frame_q;
    div_d     = div_q;
    sweep_d   = sweep_q;
    changed_d = changed_q;
    status_d  = status_q;
    rdc_d     = rdc_q;
    up_d      = up_q;
    if (cmd_i.exec) begin
      status_d = STS_IDLE;
      rdc_d    = '0;
      up_d     = 1'b0;
      unique case (func)
        FN_TICK: begin
          if (mode_q == MODE_RUN) begin
            if (tick_hit) begin
              frame_d = '0;
            end else begin
              frame_d  = frame_next[7:0];
              status_d = STS_FADING;
            end
          end
        end
        FN_UPLOAD: begin
          if (mode_q != MODE_NONE) begin
            up_d = 1'b1;
          end
          if (mode_q == MODE_LAST) begin
            mode_d = MODE_NONE;
          end
        end
        FN_START: begin
          mode_d  = MODE_RUN;
          div_d   = speed_q;
          frame_d = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.rd_issue) begin
      status_d = STS_IDLE;
      rdc_d    = '0;
      up_d     = 1'b0;
    end
    if (cmd_i.rd_capture) begin
      rdc_d = idx_ok ? cur_eff : '0;
    end
    if (cmd_i.sweep_start) begin
      sweep_d   = '0;
      changed_d = 1'b0;
    end
    if (cmd_i.sweep_rd) begin
      sweep_d = sweep_q + AW'(1);
    end
    if (wb_v_q) begin
      changed_d = changed_q || step_res[COLOR_W];
    end
    if (cmd_i.pass_end) begin
      if (changed_q || (wb_v_q && step_res[COLOR_W])) begin
        status_d = STS_FADING;
      end else begin
        status_d = STS_DONE;
        mode_d   = MODE_LAST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      frame_q   <= '0;
      div_q     <= '0;
      sweep_q   <= '0;
      changed_q <= 1'b0;
      wb_v_q    <= 1'b0;
      cur_vld_q <= '0;
      tgt_vld_q <= '0;
    end else begin
      mode_q    <= mode_d;
      frame_q   <= frame_d;
      div_q     <= div_d;
      sweep_q   <= sweep_d;
      changed_q <= changed_d;
      wb_v_q    <= cmd_i.sweep_rd;
      if (cur_we) begin
        cur_vld_q[cur_waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_q[idx_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= func_i;
      idx_q   <= index_i;
      color_q <= color_i;
      speed_q <= speed_i;
    end
    wb_addr_q <= sweep_q;
    status_q  <= status_d;
    rdc_q     <= rdc_d;
    up_q      <= up_d;
  end

  // palette memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rd_q  <= cur_mem[rd_addr];
    cur_rdv_q <= cur_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[idx_addr] <= color_q;
    end
    tgt_rd_q  <= tgt_mem[rd_addr];
    tgt_rdv_q <= tgt_vld_q[rd_addr];
  end

`ifndef SYNTHESIS
  a_frame_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RUN) |-> ({1'b0, frame_q} < limit))
    else $error("frame count reached divider while fading");
`endif

endmodule

### sv/pfe_ctrl.sv
// controller state machine sequencing requests and palette sweeps
module pfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_free_i,
  input  pfe_pkg::pfe_sts_t sts_i,
  output pfe_pkg::pfe_cmd_t cmd_o,
  output logic              result_load_o
);
  import pfe_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    result_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.func == FN_RD_CUR) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_RDWAIT;
        end else begin
          cmd_o.exec = 1'b1;
          if (sts_i.tick_pass) begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_SWEEP;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_FINISH;
      end
      ST_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.pass_end = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          result_load_o = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_item, cmd_o.exec, cmd_o.rd_issue, cmd_o.rd_capture,
              cmd_o.sweep_rd, cmd_o.pass_end, result_load_o}))
    else $error("more than one datapath command in a cycle");
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sweep_rd && sts_i.sweep_last) |=> (state_q == ST_DRAIN))
    else $error("sweep did not drain after the last entry");
`endif

endmodule

### sv/palette_fade_engine_core.sv
// top level of the palette fade engine: controller, datapath and result register
// Palette fade engine. Holds a current and a target palette of PALETTE_ENTRIES
// 12-bit colors (three 3-bit components in bits 1-3, 5-7, 9-11) and serves one
// request at a time: tick, upload check, write current, write target, start
// fade, read current. A tick that triggers a fade pass walks every entry
// through the single read and write port of the palette memories, one entry
// per cycle, and the next request is taken only after the result of the
// last one has moved into the output register. Every request yields exactly
// one result. The result sits in an output register, so the block takes the
// next request while a result still waits to be taken. Both palettes read as
// zero after reset until written; a write or read at an index at or above
// PALETTE_ENTRIES is dropped or returns zero.
module palette_fade_engine_core #(
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pfe_pkg::FUNC_W-1:0]   func_i,
  input  logic [pfe_pkg::IDX_W-1:0]    index_i,
  input  logic [pfe_pkg::COLOR_W-1:0]  color_i,
  input  logic [pfe_pkg::SPEED_W-1:0]  speed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pfe_pkg::STATUS_W-1:0] status_o,
  output logic [pfe_pkg::COLOR_W-1:0]  read_color_o,
  output logic                         upload_o
);
  import pfe_pkg::*;

  pfe_cmd_t cmd;
  pfe_sts_t sts;
  logic     result_load;
  logic     out_free;

  // datapath result fields, copied into the output register at the end
  logic [STATUS_W-1:0] dp_status;
  logic [COLOR_W-1:0]  dp_read_color;
  logic                dp_upload;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [COLOR_W-1:0]  read_color_q;
  logic                upload_q;

  // slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  pfe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .result_load_o (result_load)
  );

  pfe_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .index_i      (index_i),
    .color_i      (color_i),
    .speed_i      (speed_i),
    .status_o     (dp_status),
    .read_color_o (dp_read_color),
    .upload_o     (dp_upload)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (result_load) begin
      status_q     <= dp_status;
      read_color_q <= dp_read_color;
      upload_q     <= dp_upload;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_color_o = read_color_q;
  assign upload_o     = upload_q;

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while the previous one is still in work");
`endif

endmodule

### bench/palette_fade_engine_core_tb.sv
// self-checking testbench of the palette fade engine: directed table, then random fade sequences
module palette_fade_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned N_RANDOM     = 1600;
  localparam int unsigned QUIET_FROM   = 1450;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_PRINTS   = 100;

  // command codes outside the decoded set
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COLOR_W-1:0]  read_color;
    logic                upload;
  } fade_result_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [SPEED_W-1:0] speed;
    bit                 typed;
    fade_result_t       want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [IDX_W-1:0]    index_i;
  logic [COLOR_W-1:0]  color_i;
  logic [SPEED_W-1:0]  speed_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [COLOR_W-1:0]  read_color_o;
  logic                upload_o;

  // shadow copy of the fade engine state
  logic [COLOR_W-1:0] cur_pal [ENTRIES];
  logic [COLOR_W-1:0] tgt_pal [ENTRIES];
  fade_mode_e         mode_q;
  logic [SPEED_W-1:0] frame_cnt;
  logic [SPEED_W-1:0] divider;

  fade_result_t expected_results [$];
  stim_row_t    dir_rows [$];
  fade_result_t got_want;

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  bit          quiet          = 1'b0;  // last part of the run: no idling at all
  bit          sender_bursty  = 1'b0;
  bit          hold_off_req   = 1'b0;  // asks the receiver for one long hold-off

  palette_fade_engine_core #(
    .PALETTE_ENTRIES(ENTRIES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .color_i     (color_i),
    .speed_i     (speed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .read_color_o(read_color_o),
    .upload_o    (upload_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("palette_fade_engine_core test failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch on %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
    mismatch_count++;
  endtask

  // one fade pass over every entry, returns the number of components moved
  function automatic int unsigned step_palette();
    int unsigned        changed;
    logic [COLOR_W-1:0] cur, mask, unit;
    changed = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      cur = cur_pal[i];
      for (int k = 0; k < 3; k++) begin
        mask = 12'h00E << (4 * k);
        unit = 12'h002 << (4 * k);
        if ((cur & mask) != (tgt_pal[i] & mask)) begin
          // bits 0, 4 and 8 ride along untouched
          if ((cur & mask) < (tgt_pal[i] & mask)) cur = cur + unit;
          else cur = cur - unit;
          changed++;
        end
      end
      cur_pal[i] = cur;
    end
    return changed;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic fade_result_t apply_request(input logic [FUNC_W-1:0] f,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [COLOR_W-1:0] color,
                                                 input logic [SPEED_W-1:0] speed);
    fade_result_t r;
    int unsigned  lim;
    r = '0;
    case (f)
      FN_TICK: begin
        if (mode_q == MODE_RUN) begin
          // a divider of zero behaves as one
          lim = (divider == 0) ? 1 : int'(divider);
          if (int'(frame_cnt) + 1 >= lim) begin
            frame_cnt = '0;
            if (step_palette() == 0) begin
              mode_q   = MODE_LAST;
              r.status = STS_DONE;
            end else begin
              r.status = STS_FADING;
            end
          end else begin
            frame_cnt = frame_cnt + 1'b1;
            r.status  = STS_FADING;
          end
        end
      end
      FN_UPLOAD: begin
        if (mode_q != MODE_NONE) begin
          r.upload = 1'b1;
          if (mode_q == MODE_LAST) mode_q = MODE_NONE;
        end
      end
      FN_WR_CUR: cur_pal[idx] = color;
      FN_WR_TGT: tgt_pal[idx] = color;
      FN_START: begin
        mode_q    = MODE_RUN;
        divider   = speed;
        frame_cnt = '0;
      end
      FN_RD_CUR: r.read_color = cur_pal[idx];
      default: ;
    endcase
    return r;
  endfunction

  // offer one request, wait for its acceptance, then queue its expected result
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                              input logic [COLOR_W-1:0] color,
                              input logic [SPEED_W-1:0] speed, input bit typed,
                              input fade_result_t want);
    fade_result_t pred;
    int unsigned  gap;
    gap = 0;
    if (!quiet && sender_bursty && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= f;
    index_i    <= idx;
    color_i    <= color;
    speed_i    <= speed;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = apply_request(f, idx, color, speed);
    expected_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic send_free(input logic [FUNC_W-1:0] f);
    send_request(f, IDX_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)),
                 SPEED_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // any command code the field can carry, unused ones included
  function automatic logic [FUNC_W-1:0] FN_FUNC_ANY();
    return FUNC_W'($urandom_range(0, 7));
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                         input logic [COLOR_W-1:0] color, input logic [SPEED_W-1:0] speed,
                         input bit typed, input logic [STATUS_W-1:0] st,
                         input logic [COLOR_W-1:0] rd, input logic up);
    stim_row_t row;
    row.func            = f;
    row.idx             = idx;
    row.color           = color;
    row.speed           = speed;
    row.typed           = typed;
    row.want.status     = st;
    row.want.read_color = rd;
    row.want.upload     = up;
    dir_rows.push_back(row);
  endtask

  // load some entries, arm a fade and tick it, mostly until it finishes
  task automatic run_fade_sequence();
    int unsigned        n_wr, steps, pick;
    logic [SPEED_W-1:0] spd;
    logic [FUNC_W-1:0]  f;
    n_wr = $urandom_range(0, 6);
    repeat (n_wr) begin
      f = $urandom_range(0, 1) ? FN_WR_CUR : FN_WR_TGT;
      send_free(f);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) spd = SPEED_W'($urandom_range(0, 3));
    else if (pick < 9) spd = SPEED_W'($urandom_range(4, 20));
    else spd = SPEED_W'($urandom_range(21, 255));
    send_request(FN_START, IDX_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)),
                 spd, 1'b0, '0);
    steps = 0;
    while (mode_q != MODE_LAST && steps < 60) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) send_free(FN_TICK);
      else if (pick == 8) send_free(FN_RD_CUR);
      else send_free(FN_UPLOAD);
      steps++;
    end
    // a tick after the finish must report not fading
    if ($urandom_range(0, 1)) send_free(FN_TICK);
    send_free(FN_UPLOAD);
  endtask

  // receiver: random stall bursts, one long hold-off, none in the last part
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet) repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
    end
  end

  // result checker: every taken result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no request pending", status_o, 0);
      end else begin
        got_want = expected_results.pop_front();
        if (status_o !== got_want.status)
          flag_mismatch("status", status_o, got_want.status);
        if (read_color_o !== got_want.read_color)
          flag_mismatch("read_color", read_color_o, got_want.read_color);
        if (upload_o !== got_want.upload)
          flag_mismatch("upload", upload_o, got_want.upload);
      end
    end
  end

  // main stimulus
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = '0;
    index_i    = '0;
    color_i    = '0;
    speed_i    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cur_pal[i] = '0;
      tgt_pal[i] = '0;
    end
    mode_q    = MODE_NONE;
    frame_cnt = '0;
    divider   = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // state straight after reset
    add_row(FN_RD_CUR, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_RD_CUR, 6'd63, 12'hFFF, 8'hFF, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_UPLOAD, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);
    // unused codes do nothing
    add_row(FN_SPARE_6, 6'd63, 12'hFFF, 8'hFF, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_SPARE_7, 6'd63, 12'hFFF, 8'hFF, 1'b1, STS_IDLE, 12'h000, 1'b0);
    // color extremes and the untouched low bit of each component
    add_row(FN_WR_CUR, 6'd63, 12'hFFF, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_RD_CUR, 6'd63, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'hFFF, 1'b0);
    add_row(FN_WR_TGT, 6'd63, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_WR_CUR, 6'd0, 12'h111, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_WR_TGT, 6'd0, 12'hEEE, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    // divider of zero steps on every tick
    add_row(FN_START, 6'd0, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_UPLOAD, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b1);
    add_row(FN_RD_CUR, 6'd0, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_RD_CUR, 6'd63, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    // largest divider: the tick only waits
    add_row(FN_START, 6'd0, 12'h000, 8'hFF, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b1, STS_FADING, 12'h000, 1'b0);
    add_row(FN_START, 6'd0, 12'h000, 8'h01, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    // converged palette: the next pass finishes, then last-frame upload
    add_row(FN_WR_CUR, 6'd0, 12'hEEE, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_WR_CUR, 6'd63, 12'h000, 8'h00, 1'b0, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b1, STS_DONE, 12'h000, 1'b0);
    add_row(FN_TICK, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);
    add_row(FN_UPLOAD, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b1);
    add_row(FN_UPLOAD, 6'd0, 12'h000, 8'h00, 1'b1, STS_IDLE, 12'h000, 1'b0);

    foreach (dir_rows[i])
      send_request(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].color, dir_rows[i].speed,
                   dir_rows[i].typed, dir_rows[i].want);

    // long receiver hold-off while requests keep coming, so the block backs up
    hold_off_req = 1'b1;
    while (items_sent < dir_rows.size() + N_RANDOM) begin
      quiet         = (items_sent >= dir_rows.size() + QUIET_FROM);
      sender_bursty = $urandom_range(0, 1);
      if ($urandom_range(0, 9) < 8) begin
        run_fade_sequence();
      end else begin
        repeat ($urandom_range(1, 10)) send_free(FN_FUNC_ANY());
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("palette_fade_engine_core test passed");
    end else begin
      $display("palette_fade_engine_core test failed");
    end
    $finish;
  end

endmodule
